// File: design/pds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared constants, types and lookup functions for the multiplier and
// post-divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Search ranges and control word layout.
  localparam int unsigned M_FIRST       = 62;
  localparam int unsigned M_LAST        = 92;
  localparam int unsigned P_FIRST       = 2;
  localparam int unsigned P_LAST        = 6;
  localparam int unsigned CTRL_BIT_BASE = 15;

  // Field widths.
  localparam int unsigned REF_W    = 17;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned M_W      = 7;
  localparam int unsigned P_W      = 3;
  localparam int unsigned FREQ_W   = 24;
  localparam int unsigned TARGET_W = 26;
  localparam int unsigned CTRL_W   = 22;
  localparam int unsigned DIV_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [REF_W-1:0]  REF_CLOCK_RST = REF_W'(25000);
  localparam logic [RATE_W-1:0] MIN_RATE_RST  = RATE_W'(300);
  localparam logic [RATE_W-1:0] MAX_RATE_RST  = RATE_W'(1150);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE  = 2'd2;

  // Status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_OUT_RANGE = 1'b1;

  // Reciprocal division: floor(x / d) == (x * ceil(2^S / d)) >> S for
  // every 24-bit x and every d in 2..6 once S is 27.
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'((2**RECIP_SHIFT + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((2**RECIP_SHIFT + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP4 = RECIP_W'((2**RECIP_SHIFT + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'((2**RECIP_SHIFT + 4) / 5);
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'((2**RECIP_SHIFT + 5) / 6);

  localparam logic [FREQ_W-1:0] ERR_MAX = {FREQ_W{1'b1}};

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // One candidate frequency leaving the divide unit.
  typedef struct packed {
    logic              valid;
    logic [M_W-1:0]    m;
    logic [P_W-1:0]    p;
    logic [FREQ_W-1:0] freq;
  } cand_t;

  // Best pair found so far.
  typedef struct packed {
    logic                exact;
    logic [M_W-1:0]      m;
    logic [P_W-1:0]      p;
    logic [TARGET_W-1:0] err;
  } best_t;

  // Reciprocal constant for a post divider.
  function automatic logic [RECIP_W-1:0] recip(input logic [P_W-1:0] p);
    logic [RECIP_W-1:0] r;
    case (p)
      3'd2:    r = RECIP2;
      3'd3:    r = RECIP3;
      3'd4:    r = RECIP4;
      3'd5:    r = RECIP5;
      3'd6:    r = RECIP6;
      default: r = '0;
    endcase
    return r;
  endfunction

  // LFSR seed for multiplier index m - 62.
  function automatic logic [DIV_W-1:0] seed(input logic [4:0] idx);
    logic [DIV_W-1:0] s;
    case (idx)
      5'd0:    s = 9'd426;
      5'd1:    s = 9'd469;
      5'd2:    s = 9'd234;
      5'd3:    s = 9'd373;
      5'd4:    s = 9'd442;
      5'd5:    s = 9'd221;
      5'd6:    s = 9'd110;
      5'd7:    s = 9'd311;
      5'd8:    s = 9'd411;
      5'd9:    s = 9'd461;
      5'd10:   s = 9'd486;
      5'd11:   s = 9'd243;
      5'd12:   s = 9'd377;
      5'd13:   s = 9'd188;
      5'd14:   s = 9'd350;
      5'd15:   s = 9'd175;
      5'd16:   s = 9'd343;
      5'd17:   s = 9'd427;
      5'd18:   s = 9'd213;
      5'd19:   s = 9'd106;
      5'd20:   s = 9'd53;
      5'd21:   s = 9'd282;
      5'd22:   s = 9'd397;
      5'd23:   s = 9'd354;
      5'd24:   s = 9'd227;
      5'd25:   s = 9'd113;
      5'd26:   s = 9'd56;
      5'd27:   s = 9'd284;
      5'd28:   s = 9'd142;
      5'd29:   s = 9'd71;
      5'd30:   s = 9'd35;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: design/pds_quot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search divide unit
// Shared reciprocal multiplier that turns m * ref into (m * ref) / p for one
// candidate pair per cycle, registered.
// ----------------------------------------------------------------------------
module pds_quot (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    issue,
  input  logic [pds_pkg::FREQ_W-1:0] prod,
  input  logic [pds_pkg::M_W-1:0] m,
  input  logic [pds_pkg::P_W-1:0] p,
  output pds_pkg::cand_t          cand
);
  import pds_pkg::*;

  localparam int unsigned MUL_W = FREQ_W + RECIP_W;

  logic [MUL_W-1:0] mul;

  // Multiply by the reciprocal of p; the top bits are the exact quotient.
  assign mul = MUL_W'(prod) * MUL_W'(recip(p));

  // Valid is control state; the payload follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand.valid <= 1'b0;
    end else begin
      cand.valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cand.m    <= m;
      cand.p    <= p;
      cand.freq <= mul[MUL_W-1:RECIP_SHIFT];
    end
  end

endmodule

// File: design/pds_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search best-pair tracker
// Forms the absolute error of each candidate against the target and keeps the
// first pair with strictly smaller error, latching on an exact match.
// ----------------------------------------------------------------------------
module pds_best (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [pds_pkg::TARGET_W-1:0] target,
  input  pds_pkg::cand_t               cand,
  output pds_pkg::best_t               best
);
  import pds_pkg::*;

  logic                have;
  logic [TARGET_W-1:0] freq_ext;
  logic [TARGET_W-1:0] err;
  logic                take;

  // Absolute error of the incoming candidate.
  assign freq_ext = TARGET_W'(cand.freq);
  assign err      = (freq_ext > target) ? (freq_ext - target) : (target - freq_ext);

  // Candidates after an exact match are dropped.
  assign take = cand.valid && !best.exact &&
                ((err == '0) || !have || (err < best.err));

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      have       <= 1'b0;
      best.exact <= 1'b0;
    end else if (cand.valid && !best.exact) begin
      have <= 1'b1;
      if (err == '0) begin
        best.exact <= 1'b1;
      end
    end
  end

  // Best pair payload.
  always_ff @(posedge clk) begin
    if (take) begin
      best.m   <= cand.m;
      best.p   <= cand.p;
      best.err <= err;
    end
  end

endmodule

// File: design/pll_divider_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search
// Finds the PLL multiplier and post divider closest to a requested link clock
// and returns the packed control and divider words.
// ----------------------------------------------------------------------------
// One rate is taken at a time. A rate outside the configured bounds skips the
// search and returns an error beat. Any other rate walks the pairs m = 62..92,
// p = 2..6 through one reciprocal multiplier at one pair a cycle, up to 155
// pairs in all, and ends early at the first exact match. The input stays
// stalled from acceptance until the result is loaded into the output register;
// a waiting result delays the load of the next one.
module pll_divider_search (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pds_pkg::REF_W-1:0]        cfg_data,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pds_pkg::RATE_W-1:0]       rate_mhz,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             status,
  output logic [pds_pkg::CTRL_W-1:0]       ctrl_word,
  output logic [pds_pkg::DIV_W-1:0]        div_word,
  output logic [pds_pkg::M_W-1:0]          mult,
  output logic [pds_pkg::P_W-1:0]          post_div,
  output logic [pds_pkg::FREQ_W-1:0]       freq_error_khz
);
  import pds_pkg::*;

  state_t state, state_next;

  logic [REF_W-1:0]    ref_clock_khz;
  logic [RATE_W-1:0]   min_rate_mhz;
  logic [RATE_W-1:0]   max_rate_mhz;

  logic [TARGET_W-1:0] target;
  logic                range_err;
  logic [FREQ_W-1:0]   prod;
  logic [M_W-1:0]      m;
  logic [P_W-1:0]      p;
  logic                issue_done;

  logic                accept;
  logic                issue;
  logic                load;
  logic                out_range;

  cand_t               cand;
  best_t               best;

  // Configuration registers; writes must arrive only while idle (the user's duty, not checked by the block).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_khz <= REF_CLOCK_RST;
      min_rate_mhz  <= MIN_RATE_RST;
      max_rate_mhz  <= MAX_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_CLOCK: ref_clock_khz <= cfg_data;
        REG_MIN_RATE:  min_rate_mhz  <= cfg_data[RATE_W-1:0];
        REG_MAX_RATE:  max_rate_mhz  <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_range = (rate_mhz < min_rate_mhz) || (rate_mhz > max_rate_mhz);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    issue      = 1'b0;
    load       = 1'b0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = out_range ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        issue = !issue_done && !best.exact;
        if (best.exact || (issue_done && !cand.valid)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        load = !out_valid || !out_stall;
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pair counters and running product m * ref.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_done <= 1'b0;
    end else if (accept) begin
      issue_done <= 1'b0;
    end else if (issue && (p == P_W'(P_LAST)) && (m == M_W'(M_LAST))) begin
      issue_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target    <= TARGET_W'(rate_mhz) * TARGET_W'(1000);
      range_err <= out_range;
      m         <= M_W'(M_FIRST);
      p         <= P_W'(P_FIRST);
      prod      <= (FREQ_W'(ref_clock_khz) << 6) - (FREQ_W'(ref_clock_khz) << 1);
    end else if (issue) begin
      if (p == P_W'(P_LAST)) begin
        p    <= P_W'(P_FIRST);
        m    <= m + M_W'(1);
        prod <= prod + FREQ_W'(ref_clock_khz);
      end else begin
        p <= p + P_W'(1);
      end
    end
  end

  // Shared divide unit and best-pair tracker.
  pds_quot u_quot (
    .clk  (clk),
    .rst  (rst),
    .issue(issue),
    .prod (prod),
    .m    (m),
    .p    (p),
    .cand (cand)
  );

  pds_best u_best (
    .clk   (clk),
    .rst   (rst),
    .clear (accept),
    .target(target),
    .cand  (cand),
    .best  (best)
  );

  // Result register; a beat leaves when the far side does not stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (range_err) begin
        status         <= STATUS_OUT_RANGE;
        ctrl_word      <= '0;
        div_word       <= '0;
        mult           <= '0;
        post_div       <= '0;
        freq_error_khz <= '0;
      end else begin
        status         <= STATUS_OK;
        ctrl_word      <= CTRL_W'(1) << (5'(CTRL_BIT_BASE) + 5'(best.p));
        div_word       <= seed(5'(best.m - M_W'(M_FIRST)));
        mult           <= best.m;
        post_div       <= best.p;
        freq_error_khz <= (|best.err[TARGET_W-1:FREQ_W]) ? ERR_MAX
                                                          : best.err[FREQ_W-1:0];
      end
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search testbench
// Drives requested link rates into the search block under several reference
// clock and rate bound settings. A local predictor computes the best
// multiplier and post divider for each accepted rate. Every result beat is
// checked field by field, in order, against the predicted settings.
// ----------------------------------------------------------------------------
module tb;
  import pds_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles with no accepted beat on any channel before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 4000;

  // LFSR seeds of the multipliers, first entry for m = 62.
  localparam logic [0:30][DIV_W-1:0] LFSR_SEED = {
    9'd426, 9'd469, 9'd234, 9'd373, 9'd442, 9'd221, 9'd110, 9'd311, 9'd411,
    9'd461, 9'd486, 9'd243, 9'd377, 9'd188, 9'd350, 9'd175, 9'd343, 9'd427,
    9'd213, 9'd106, 9'd53,  9'd282, 9'd397, 9'd354, 9'd227, 9'd113, 9'd56,
    9'd284, 9'd142, 9'd71,  9'd35
  };

  // One complete PLL setting as the block reports it.
  typedef struct packed {
    logic              status;
    logic [CTRL_W-1:0] ctrl;
    logic [DIV_W-1:0]  div;
    logic [M_W-1:0]    mult;
    logic [P_W-1:0]    pdiv;
    logic [FREQ_W-1:0] ferr;
  } pll_setting_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REF_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RATE_W-1:0]    rate_mhz = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 status;
  logic [CTRL_W-1:0]    ctrl_word;
  logic [DIV_W-1:0]     div_word;
  logic [M_W-1:0]       mult;
  logic [P_W-1:0]       post_div;
  logic [FREQ_W-1:0]    freq_error_khz;

  // Register copies as the predictor sees them.
  int unsigned cur_ref_khz  = 25000;
  int unsigned cur_min_rate = 300;
  int unsigned cur_max_rate = 1150;

  pll_setting_t pending_settings[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int          error_count = 0;
  int          rates_sent = 0;
  int          reg_writes = 0;
  int          searches_checked = 0;
  int          range_errors_checked = 0;

  pll_divider_search i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rate_mhz       (rate_mhz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .ctrl_word      (ctrl_word),
    .div_word       (div_word),
    .mult           (mult),
    .post_div       (post_div),
    .freq_error_khz (freq_error_khz)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk every multiplier and post divider pair in search order and keep the
  // first pair with strictly smaller error, stopping at an exact match.
  function automatic pll_setting_t best_pll_setting(input logic [RATE_W-1:0] rate);
    pll_setting_t s;
    int unsigned  target;
    int unsigned  freq;
    int unsigned  err;
    int unsigned  best_err;
    int unsigned  m;
    int unsigned  p;
    int unsigned  best_m;
    int unsigned  best_p;
    bit           have;
    bit           exact;
    s = '0;
    if (rate < cur_min_rate || rate > cur_max_rate) begin
      s.status = STATUS_OUT_RANGE;
      return s;
    end
    target = rate * 1000;
    best_err = 0;
    best_m = M_FIRST;
    best_p = P_FIRST;
    have = 1'b0;
    exact = 1'b0;
    for (m = M_FIRST; m <= M_LAST && !exact; m++) begin
      for (p = P_FIRST; p <= P_LAST && !exact; p++) begin
        freq = (m * cur_ref_khz) / p;
        err = (freq > target) ? freq - target : target - freq;
        if (!have || err < best_err) begin
          have = 1'b1;
          best_err = err;
          best_m = m;
          best_p = p;
        end
        if (err == 0) exact = 1'b1;
      end
    end
    s.status = STATUS_OK;
    s.ctrl = CTRL_W'(1) << (CTRL_BIT_BASE + best_p);
    s.div = LFSR_SEED[best_m - M_FIRST];
    s.mult = M_W'(best_m);
    s.pdiv = P_W'(best_p);
    s.ferr = (best_err > ERR_MAX) ? ERR_MAX : FREQ_W'(best_err);
    return s;
  endfunction

  task automatic report_field(input string field, input logic [23:0] want,
                              input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    pll_setting_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_settings.size() == 0) begin
        $display("%0t: result beat with no request waiting, expected none, actual mult %0d",
                 $time, mult);
        error_count++;
      end else begin
        want = pending_settings.pop_front();
        report_field("status", 24'(want.status), 24'(status));
        report_field("ctrl_word", 24'(want.ctrl), 24'(ctrl_word));
        report_field("div_word", 24'(want.div), 24'(div_word));
        report_field("mult", 24'(want.mult), 24'(mult));
        report_field("post_div", 24'(want.pdiv), 24'(post_div));
        report_field("freq_error_khz", want.ferr, freq_error_khz);
        if (want.status == STATUS_OK) searches_checked++;
        else range_errors_checked++;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one rate, with random idle cycles first, and record its prediction
  // when the beat is taken. Valid stays high for the caller to reuse.
  task automatic send_rate(input logic [RATE_W-1:0] r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rate_mhz <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_settings.push_back(best_pll_setting(r));
    rates_sent++;
  endtask

  // Hold the request channel until every result is back, then let the block
  // settle for a few cycles.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write beat. Valid is left high; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REF_CLOCK: cur_ref_khz = data;
      REG_MIN_RATE:  cur_min_rate = data[RATE_W-1:0];
      REG_MAX_RATE:  cur_max_rate = data[RATE_W-1:0];
      default:       ;
    endcase
    reg_writes++;
  endtask

  // Program all three registers once the block is idle. The unused top bit
  // of the rate bounds is set at random; only the low 16 bits count.
  task automatic apply_settings(input int unsigned ref_khz, input int unsigned min_rate,
                                input int unsigned max_rate);
    drain_results();
    write_reg(REG_REF_CLOCK, REF_W'(ref_khz));
    write_reg(REG_MIN_RATE, {1'($urandom_range(0, 1)), RATE_W'(min_rate)});
    write_reg(REG_MAX_RATE, {1'($urandom_range(0, 1)), RATE_W'(max_rate)});
    cfg_valid <= 1'b0;
  endtask

  // Mostly rates inside the bounds, some near a reachable frequency, some
  // anywhere in the field.
  function automatic logic [RATE_W-1:0] pick_rate();
    int unsigned sel;
    int unsigned m;
    int unsigned p;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      return RATE_W'($urandom_range(cur_min_rate, cur_max_rate));
    end else if (sel < 85) begin
      m = $urandom_range(M_FIRST, M_LAST);
      p = $urandom_range(P_FIRST, P_LAST);
      return RATE_W'(((m * cur_ref_khz) / p) / 1000);
    end
    return RATE_W'($urandom_range(0, 65535));
  endfunction

  // Pick a reference clock and bounds that mostly frame the reachable band.
  task automatic pick_random_settings();
    int unsigned ref_khz;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 9))
      0:       ref_khz = $urandom_range(0, 131071);
      1, 2, 3: ref_khz = $urandom_range(1, 100) * 1000;
      default: ref_khz = $urandom_range(1000, 100000);
    endcase
    lo = ((M_FIRST * ref_khz) / P_LAST) / 1000;
    hi = ((M_LAST * ref_khz) / P_FIRST + 999) / 1000;
    if ($urandom_range(0, 5) == 0) begin
      // Anything goes, inverted bounds included.
      apply_settings(ref_khz, $urandom_range(0, 65535), $urandom_range(0, 65535));
    end else begin
      apply_settings(ref_khz, (lo > 20) ? lo - $urandom_range(0, 20) : 0,
                     hi + $urandom_range(0, 20));
    end
  endtask

  // Bounds and exact matches at the reset settings.
  task automatic test_reset_settings();
    send_rate(16'd299);
    send_rate(16'd300);
    send_rate(16'd1150);
    send_rate(16'd1151);
    send_rate(16'd0);
    send_rate(16'd65535);
    send_rate(16'd775);
    send_rate(16'd400);
    send_rate(16'd1000);
    send_rate(16'd1023);
  endtask

  // Register extremes: zero and full-scale reference clock, saturated error,
  // inverted and single-point bounds, and a write to the unused index.
  task automatic test_register_extremes();
    apply_settings(0, 0, 65535);
    send_rate(16'd0);
    send_rate(16'd1);
    send_rate(16'd65535);
    apply_settings(131071, 0, 65535);
    send_rate(16'd6029);
    send_rate(16'd3000);
    send_rate(16'd65535);
    apply_settings(1000, 0, 65535);
    send_rate(16'd46);
    send_rate(16'd12);
    send_rate(16'd65535);
    apply_settings(25000, 500, 499);
    send_rate(16'd499);
    send_rate(16'd500);
    apply_settings(25000, 700, 700);
    write_reg(REG_UNUSED, REF_W'($urandom_range(0, 131071)));
    cfg_valid <= 1'b0;
    send_rate(16'd699);
    send_rate(16'd700);
    send_rate(16'd701);
  endtask

  // Random searches over several settings with the given idle rates. Once
  // per phase the sender holds off until every result has come back.
  task automatic test_random_searches(input int unsigned idle_pct,
                                      input int unsigned stall_pct);
    int s;
    int i;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (s = 0; s < 4; s++) begin
      pick_random_settings();
      for (i = 0; i < 50; i++) begin
        if (s == 1 && i == 25) drain_results();
        send_rate(pick_rate());
      end
    end
  endtask

  initial begin
    send_idle_pct = 14;
    recv_stall_pct = 60;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_register_extremes();
    test_random_searches(14, 60);
    test_random_searches(60, 14);
    test_random_searches(0, 0);

    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d rate requests across %0d register writes.", rates_sent, reg_writes);
    $display("Checked %0d searches and %0d out-of-range replies.", searches_checked,
             range_errors_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
